// ===== rtl/tlpt_pkg.sv =====
// Package with shared types and constants for the two-level page table engine.
`timescale 1ns / 1ps
`default_nettype none

package tlpt_pkg;

    // Size of the table pool and of the directory.
    localparam int TABLE_SLOTS = 8;
    localparam int DIR_ENTRIES = 1024;
    localparam int TBL_ENTRIES = 1024;

    // Derived widths.
    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
    localparam int DIR_AW = $clog2(DIR_ENTRIES);
    localparam int IDX_W  = $clog2(TBL_ENTRIES);
    localparam int PG_AW  = $clog2(TABLE_SLOTS * TBL_ENTRIES);
    localparam int DIR_DW = 1 + SLOT_W;
    localparam int PTE_W  = 23;

    // Request codes.
    localparam logic [1:0] ACT_MAP  = 2'd0;
    localparam logic [1:0] ACT_TEST = 2'd1;
    localparam logic [1:0] ACT_FIND = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] phys_addr;
        logic [31:0] virt_addr;
        logic [31:0] length_bytes;
        logic        user_access;
        logic        write_access;
    } t_req;

    typedef struct packed {
        logic        status;
        logic        range_free;
        logic [31:0] found_addr;
    } t_rsp;

endpackage

`default_nettype wire

// ===== rtl/two_level_page_table_engine.sv =====
// Top level of the two-level page table engine: sequencer around two RAMs.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+---------------------
//  request | i_valid | o_stall | i_req  (tlpt_pkg::t_req)
//  result  | o_valid | i_stall | o_rsp  (tlpt_pkg::t_rsp)
//
// After reset the directory RAM is swept clear before a request is taken.
// A request walks its range one page at a time: a map steps through the CHK, RD
// and DIR states per page, a test or search also through PG where the directory
// entry is present. Taking a new table adds a sweep that clears it in the page RAM.
// One request is in work at a time; the finished result sits in an output
// register, so the next request is taken while that result is stalled.
`timescale 1ns / 1ps
`default_nettype none

module two_level_page_table_engine (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire tlpt_pkg::t_req i_req,
    output logic                o_valid,
    input  wire logic           i_stall,
    output tlpt_pkg::t_rsp      o_rsp
);
    import tlpt_pkg::*;

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_DIR  = 3'd4;
    localparam logic [2:0] ST_PG   = 3'd5;
    localparam logic [2:0] ST_TCLR = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(TBL_ENTRIES - 1);

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_act, n_act;
    logic [19:0]       r_vpn, n_vpn;
    logic [19:0]       r_ppn, n_ppn;
    logic [20:0]       r_cnt, n_cnt;
    logic              r_user, n_user;
    logic              r_wr, n_wr;
    logic [32:0]       r_cur, n_cur;
    logic [32:0]       r_run, n_run;
    logic [31:0]       r_size, n_size;
    logic [CNT_W-1:0]  r_taken, n_taken;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [IDX_W-1:0]  r_clr, n_clr;
    t_rsp              r_res, n_res;
    logic              r_oval, n_oval;
    t_rsp              r_out, n_out;

    logic              dir_we;
    logic [DIR_AW-1:0] dir_waddr;
    logic [DIR_DW-1:0] dir_wdata;
    logic [DIR_DW-1:0] dir_rdata;
    logic              pg_we;
    logic [PG_AW-1:0]  pg_waddr;
    logic [PTE_W-1:0]  pg_wdata;
    logic [PTE_W-1:0]  pg_rdata;
    logic [PG_AW-1:0]  pg_raddr;
    logic              d_pres;
    logic [SLOT_W-1:0] d_slot;

    assign d_pres   = dir_rdata[DIR_DW-1];
    assign d_slot   = dir_rdata[SLOT_W-1:0];
    assign pg_raddr = PG_AW'({d_slot, r_vpn[IDX_W-1:0]});

    tlpt_ram #(.WIDTH(DIR_DW), .DEPTH(DIR_ENTRIES)) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_waddr (dir_waddr),
        .i_wdata (dir_wdata),
        .i_raddr (r_vpn[19:10]),
        .o_rdata (dir_rdata)
    );

    tlpt_ram #(.WIDTH(PTE_W), .DEPTH(TABLE_SLOTS * TBL_ENTRIES)) u_pg_ram (
        .i_clk   (i_clk),
        .i_we    (pg_we),
        .i_waddr (pg_waddr),
        .i_wdata (pg_wdata),
        .i_raddr (pg_raddr),
        .o_rdata (pg_rdata)
    );

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_oval;
    assign o_rsp   = r_out;

    // Sequencer: walks the range page by page and drives both RAM write ports.
    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_vpn     = r_vpn;
        n_ppn     = r_ppn;
        n_cnt     = r_cnt;
        n_user    = r_user;
        n_wr      = r_wr;
        n_cur     = r_cur;
        n_run     = r_run;
        n_size    = r_size;
        n_taken   = r_taken;
        n_slot    = r_slot;
        n_clr     = r_clr;
        n_res     = r_res;
        n_oval    = r_oval && i_stall;
        n_out     = r_out;
        dir_we    = 1'b0;
        dir_waddr = r_vpn[19:10];
        dir_wdata = {1'b1, SLOT_W'(r_taken)};
        pg_we     = 1'b0;
        pg_waddr  = PG_AW'({d_slot, r_vpn[IDX_W-1:0]});
        pg_wdata  = {r_ppn, r_user, r_wr, 1'b1};

        unique case (r_state)
            ST_INIT: begin
                dir_we    = 1'b1;
                dir_waddr = r_clr;
                dir_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == DIR_AW'(DIR_ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_act   = i_req.action;
                    n_vpn   = i_req.virt_addr[31:12];
                    n_ppn   = i_req.phys_addr[31:12];
                    n_cnt   = 21'(({1'b0, i_req.length_bytes} + 33'd4095) >> 12);
                    n_user  = i_req.user_access;
                    n_wr    = i_req.write_access;
                    n_cur   = {1'b0, i_req.virt_addr};
                    n_run   = '0;
                    n_size  = i_req.length_bytes;
                    n_res   = '0;
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                priority if (r_act == ACT_MAP || r_act == ACT_TEST) begin
                    if (r_cnt == '0) begin
                        n_res.range_free = (r_act == ACT_TEST);
                        n_state          = ST_FIN;
                    end else begin
                        n_state = ST_RD;
                    end
                end else if (r_act == ACT_FIND) begin
                    priority if (r_cur == '0 || r_cur[32]) begin
                        n_state = ST_FIN;
                    end else if (r_run >= {1'b0, r_size}) begin
                        n_res.found_addr = r_cur[31:0] - r_size;
                        n_state          = ST_FIN;
                    end else begin
                        n_vpn   = r_cur[31:12];
                        n_state = ST_RD;
                    end
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_RD: begin
                n_state = ST_DIR;
            end
            ST_DIR: begin
                if (r_act == ACT_MAP) begin
                    priority if (d_pres) begin
                        pg_we   = 1'b1;
                        n_vpn   = r_vpn + 1'b1;
                        n_ppn   = r_ppn + 1'b1;
                        n_cnt   = r_cnt - 1'b1;
                        n_state = ST_CHK;
                    end else if (r_taken >= CNT_W'(TABLE_SLOTS)) begin
                        n_res.status = 1'b1;
                        n_state      = ST_FIN;
                    end else begin
                        dir_we  = 1'b1;
                        n_slot  = SLOT_W'(r_taken);
                        n_taken = r_taken + 1'b1;
                        n_clr   = '0;
                        n_state = ST_TCLR;
                    end
                end else if (d_pres) begin
                    n_state = ST_PG;
                end else if (r_act == ACT_TEST) begin
                    n_vpn   = r_vpn + 1'b1;
                    n_cnt   = r_cnt - 1'b1;
                    n_state = ST_CHK;
                end else begin
                    n_run   = r_run + 33'd4096;
                    n_cur   = r_cur + 33'd4096;
                    n_state = ST_CHK;
                end
            end
            ST_PG: begin
                if (r_act == ACT_TEST) begin
                    if (pg_rdata[0]) begin
                        n_state = ST_FIN;
                    end else begin
                        n_vpn   = r_vpn + 1'b1;
                        n_cnt   = r_cnt - 1'b1;
                        n_state = ST_CHK;
                    end
                end else begin
                    n_run   = pg_rdata[0] ? '0 : r_run + 33'd4096;
                    n_cur   = r_cur + 33'd4096;
                    n_state = ST_CHK;
                end
            end
            ST_TCLR: begin
                // Clear the new table; then look the page up again.
                pg_we    = 1'b1;
                pg_waddr = PG_AW'({r_slot, r_clr});
                pg_wdata = '0;
                n_clr    = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = ST_RD;
                end
            end
            ST_FIN: begin
                if (!r_oval || !i_stall) begin
                    n_oval  = 1'b1;
                    n_out   = r_res;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers are reset; the request fields are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_clr   <= '0;
            r_taken <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_taken <= n_taken;
            r_oval  <= n_oval;
        end
        r_act  <= n_act;
        r_vpn  <= n_vpn;
        r_ppn  <= n_ppn;
        r_cnt  <= n_cnt;
        r_user <= n_user;
        r_wr   <= n_wr;
        r_cur  <= n_cur;
        r_run  <= n_run;
        r_size <= n_size;
        r_slot <= n_slot;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // The pool count never passes the number of slots.
    a_taken_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_taken <= CNT_W'(TABLE_SLOTS))
        else $error("table pool count out of range");

    // A slot is handed out only together with a directory write.
    a_taken_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_taken != $past(r_taken)) |-> $past(dir_we))
        else $error("slot taken without directory update");

    // An accepted request starts its walk in the next cycle.
    a_accept_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == ST_CHK))
        else $error("accepted request did not start");

    // Page and directory writes never clash during the table sweep.
    a_sweep_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TCLR) |-> (pg_we && !dir_we))
        else $error("write conflict during table sweep");

endmodule

`default_nettype wire

// ===== rtl/tlpt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tlpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
